/* rtl/core/mhjs_pkg.sv */
// ----------------------------------------------------------------------------
// mhjs_pkg: shared types and constants of the min-heap job scheduler
// Fixed field widths of the job, result and configuration ports, and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package mhjs_pkg;

  localparam int JOB_DURATION_W = 32;
  localparam int WORKER_ID_W    = 8;
  localparam int START_TIME_W   = 48;
  localparam int CFG_DATA_W     = 9;

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_PICK  = 5'b01000,
    ST_PLACE = 5'b10000
  } mhjs_state_t;

endpackage

/* rtl/core/mhjs_if.sv */
// ----------------------------------------------------------------------------
// mhjs_if: valid/ready channels of the min-heap job scheduler
// One interface for incoming jobs and one for scheduling results.
// ----------------------------------------------------------------------------
interface mhjs_job_if;
  logic                                valid;
  logic                                ready;
  logic [mhjs_pkg::JOB_DURATION_W-1:0] job_duration;

  modport source (output valid, output job_duration, input ready);
  modport sink   (input valid, input job_duration, output ready);
endinterface

interface mhjs_res_if;
  logic                              valid;
  logic                              ready;
  logic [mhjs_pkg::WORKER_ID_W-1:0]  worker_id;
  logic [mhjs_pkg::START_TIME_W-1:0] start_time;

  modport source (output valid, output worker_id, output start_time, input ready);
  modport sink   (input valid, input worker_id, input start_time, output ready);
endinterface

/* rtl/core/min_heap_job_scheduler.sv */
// ----------------------------------------------------------------------------
// min_heap_job_scheduler: assigns jobs to the earliest free worker
// Workers sit in a binary min-heap keyed by (free time, worker id).
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on in_job carries one job duration. The block answers with
// one transfer on out_result: the worker that becomes free earliest (lower
// id on a tie) and the time it starts the job. That worker's free time then
// grows by the duration, saturating at the top of the time range, and the
// worker sifts down the heap.
// The result is registered and valid in the cycle after the job transfer.
// The heap root lives in registers; the other entries sit in a dual-read
// RAM. After a job transfer the ADD state computes the worker's new free
// time, then the worker descends L heap levels (at most
// floor(log2(worker_count))) before in_job can be ready again; each level
// compares the two children (PICK) and then the winner with the moving
// worker (PLACE), all on one shared comparator, until the worker settles
// at a leaf or stops above one.
// After reset, and after every write of cfg_data, an init pass writes one
// heap entry per cycle, worker_count entries in all, with in_job not ready.
// A new job is taken only while the result register is empty or being
// drained, so a stalled receiver holds off the input side.
// ----------------------------------------------------------------------------
module min_heap_job_scheduler #(
  parameter int MAX_WORKERS = 256,
  parameter int TIME_BITS   = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mhjs_job_if.sink                        in_job,
  mhjs_res_if.source                      out_result,
  input  logic                            cfg_we,
  input  logic [mhjs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W   = $clog2(MAX_WORKERS + 1);
  localparam int CH_W    = IDX_W + 2;
  localparam int SUM_W   = ((TIME_BITS > mhjs_pkg::JOB_DURATION_W) ? TIME_BITS
                                                                    : mhjs_pkg::JOB_DURATION_W) + 1;
  localparam int ENTRY_W = IDX_W + TIME_BITS;

  mhjs_pkg::mhjs_state_t state_r, state_nxt;

  logic [CNT_W-1:0]                        count_r, count_nxt;
  logic [IDX_W-1:0]                        init_k_r, init_k_nxt;
  logic [IDX_W-1:0]                        pos_r, pos_nxt;
  logic [mhjs_pkg::JOB_DURATION_W-1:0]     dur_r, dur_nxt;
  logic [IDX_W-1:0]                        cur_wid_r, cur_wid_nxt;
  logic [TIME_BITS-1:0]                    cur_time_r, cur_time_nxt;
  logic [IDX_W-1:0]                        win_wid_r, win_wid_nxt;
  logic [TIME_BITS-1:0]                    win_time_r, win_time_nxt;
  logic [IDX_W-1:0]                        win_idx_r, win_idx_nxt;
  logic [IDX_W-1:0]                        root_wid_r, root_wid_nxt;
  logic [TIME_BITS-1:0]                    root_time_r, root_time_nxt;
  logic                                    out_valid_r, out_valid_nxt;
  logic [mhjs_pkg::WORKER_ID_W-1:0]        out_wid_r, out_wid_nxt;
  logic [mhjs_pkg::START_TIME_W-1:0]       out_time_r, out_time_nxt;

  logic                 in_ready;
  logic                 in_fire;
  logic [CNT_W-1:0]     cfg_count;
  logic [CH_W-1:0]      left_cur, right_cur, left_nxt, right_nxt;
  logic [CH_W-1:0]      pos_ext, cnt_ext;
  logic                 has_left, has_right;
  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] sat_time;
  logic [15:0]          root_wid_ext;
  logic [63:0]          root_time_ext;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata_l, ram_rdata_r;
  logic [IDX_W-1:0]     rd_l_wid, rd_r_wid;
  logic [TIME_BITS-1:0] rd_l_time, rd_r_time;

  // Shared comparator operands
  logic [IDX_W-1:0]     cmp_a_wid, cmp_b_wid;
  logic [TIME_BITS-1:0] cmp_a_time, cmp_b_time;
  logic                 a_first;

  mhjs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WORKERS)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (left_nxt[IDX_W-1:0]),
    .raddr_b (right_nxt[IDX_W-1:0]),
    .rdata_a (ram_rdata_l),
    .rdata_b (ram_rdata_r)
  );

  assign {rd_l_wid, rd_l_time} = ram_rdata_l;
  assign {rd_r_wid, rd_r_time} = ram_rdata_r;

  assign in_ready = (state_r == mhjs_pkg::ST_IDLE) && (!out_valid_r || out_result.ready);
  assign in_fire  = in_job.valid && in_ready;

  assign in_job.ready          = in_ready;
  assign out_result.valid      = out_valid_r;
  assign out_result.worker_id  = out_wid_r;
  assign out_result.start_time = out_time_r;

  // A write of zero counts as one worker; anything above the heap size is clamped.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_count = CNT_W'(1);
    end else if (int'(cfg_data) > MAX_WORKERS) begin
      cfg_count = CNT_W'(MAX_WORKERS);
    end else begin
      cfg_count = CNT_W'(cfg_data);
    end
  end

  assign left_cur  = CH_W'({pos_r, 1'b1});
  assign right_cur = left_cur + CH_W'(1);
  assign left_nxt  = CH_W'({pos_nxt, 1'b1});
  assign right_nxt = left_nxt + CH_W'(1);
  assign pos_ext   = CH_W'(pos_r);
  assign cnt_ext   = CH_W'(count_r);
  assign has_left  = left_cur < cnt_ext;
  assign has_right = right_cur < cnt_ext;

  assign sum      = SUM_W'(root_time_r) + SUM_W'(dur_r);
  assign sat_time = (|sum[SUM_W-1:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];

  assign root_wid_ext  = 16'(root_wid_r);
  assign root_time_ext = 64'(root_time_r);

  // One comparator: children against each other, then the winner against
  // the worker being sifted down.
  always_comb begin
    if (state_r == mhjs_pkg::ST_PLACE) begin
      cmp_a_wid  = win_wid_r;
      cmp_a_time = win_time_r;
      cmp_b_wid  = cur_wid_r;
      cmp_b_time = cur_time_r;
    end else begin
      cmp_a_wid  = rd_r_wid;
      cmp_a_time = rd_r_time;
      cmp_b_wid  = rd_l_wid;
      cmp_b_time = rd_l_time;
    end
    a_first = (cmp_a_time < cmp_b_time) ||
              ((cmp_a_time == cmp_b_time) && (cmp_a_wid < cmp_b_wid));
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    init_k_nxt    = init_k_r;
    pos_nxt       = pos_r;
    dur_nxt       = dur_r;
    cur_wid_nxt   = cur_wid_r;
    cur_time_nxt  = cur_time_r;
    win_wid_nxt   = win_wid_r;
    win_time_nxt  = win_time_r;
    win_idx_nxt   = win_idx_r;
    root_wid_nxt  = root_wid_r;
    root_time_nxt = root_time_r;
    out_valid_nxt = out_valid_r && !out_result.ready;
    out_wid_nxt   = out_wid_r;
    out_time_nxt  = out_time_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = {cur_wid_r, cur_time_r};

    unique case (state_r)
      mhjs_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_k_r;
        ram_wdata = {init_k_r, {TIME_BITS{1'b0}}};
        if (CNT_W'(init_k_r) + CNT_W'(1) == count_r) begin
          state_nxt = mhjs_pkg::ST_IDLE;
        end else begin
          init_k_nxt = init_k_r + IDX_W'(1);
        end
      end
      mhjs_pkg::ST_IDLE: begin
        if (in_fire) begin
          dur_nxt       = in_job.job_duration;
          pos_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_wid_nxt   = root_wid_ext[mhjs_pkg::WORKER_ID_W-1:0];
          out_time_nxt  = root_time_ext[mhjs_pkg::START_TIME_W-1:0];
          state_nxt     = mhjs_pkg::ST_ADD;
        end
      end
      mhjs_pkg::ST_ADD: begin
        cur_wid_nxt  = root_wid_r;
        cur_time_nxt = sat_time;
        state_nxt    = mhjs_pkg::ST_PICK;
      end
      mhjs_pkg::ST_PICK: begin
        if (!has_left) begin
          // Reached a leaf: the moving worker settles here.
          ram_we    = 1'b1;
          state_nxt = mhjs_pkg::ST_IDLE;
        end else if (has_right && a_first) begin
          win_wid_nxt  = rd_r_wid;
          win_time_nxt = rd_r_time;
          win_idx_nxt  = right_cur[IDX_W-1:0];
          state_nxt    = mhjs_pkg::ST_PLACE;
        end else begin
          win_wid_nxt  = rd_l_wid;
          win_time_nxt = rd_l_time;
          win_idx_nxt  = left_cur[IDX_W-1:0];
          state_nxt    = mhjs_pkg::ST_PLACE;
        end
      end
      mhjs_pkg::ST_PLACE: begin
        ram_we = 1'b1;
        if (a_first) begin
          // The child moves up and the worker continues one level down.
          ram_wdata = {win_wid_r, win_time_r};
          pos_nxt   = win_idx_r;
          state_nxt = mhjs_pkg::ST_PICK;
        end else begin
          state_nxt = mhjs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mhjs_pkg::ST_INIT;
      end
    endcase

    // Entry zero is kept in registers so the next job sees the root at once.
    if (ram_we && ram_waddr == '0) begin
      {root_wid_nxt, root_time_nxt} = ram_wdata;
    end

    if (cfg_we) begin
      count_nxt  = cfg_count;
      init_k_nxt = '0;
      state_nxt  = mhjs_pkg::ST_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhjs_pkg::ST_INIT;
      count_r     <= CNT_W'(1);
      init_k_r    <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      init_k_r    <= init_k_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dur_r       <= dur_nxt;
    cur_wid_r   <= cur_wid_nxt;
    cur_time_r  <= cur_time_nxt;
    win_wid_r   <= win_wid_nxt;
    win_time_r  <= win_time_nxt;
    win_idx_r   <= win_idx_nxt;
    root_wid_r  <= root_wid_nxt;
    root_time_r <= root_time_nxt;
    out_wid_r   <= out_wid_nxt;
    out_time_r  <= out_time_nxt;
  end

  a_result_follows_job: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("job transfer did not load the result register");

  a_sift_descends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mhjs_pkg::ST_PLACE && a_first) |=> (pos_r > $past(pos_r)))
    else $error("sift-down did not move to a deeper entry");

  a_pos_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mhjs_pkg::ST_PICK) |-> (pos_ext < cnt_ext))
    else $error("sift position outside the active heap");

  a_cfg_restarts_init: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == mhjs_pkg::ST_INIT && init_k_r == '0))
    else $error("worker count write did not restart the init pass");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_result.ready) |-> !in_job.ready)
    else $error("job taken while a result is stalled");

endmodule

/* rtl/core/mhjs_ram.sv */
// ----------------------------------------------------------------------------
// mhjs_ram: generic RAM, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mhjs_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule
